FILE: rtl/range_min_segment_tree_assert.svh
// assertion macros for the checker file
// expects signals named clock and reset in the scope of use
`ifndef RANGE_MIN_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_ASSERT_SVH

// checked outside reset only
`define RMST_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RMST_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/rmst_pkg.sv
// types and constants of the range minimum segment tree
// no dependencies
package rmst_pkg;

   localparam int unsigned LEAVES_DEF = 1024;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned INDEX_W    = 10;
   localparam int unsigned VALUE_W    = 24;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [VALUE_W-1:0] value_type;

   localparam value_type INF_VALUE = 24'd10000000;

   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_QUERY = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

endpackage

FILE: rtl/rmst_req_if.sv
// command channel: valid/ready plus one command item
// depends on rmst_pkg
interface rmst_req_if import rmst_pkg::*; ();
   logic      valid;
   logic      ready;
   cmd_type   cmd;
   index_type index_lo;
   index_type index_hi;
   value_type value;

   modport source (output valid, output cmd, output index_lo, output index_hi,
                   output value, input ready);
   modport sink   (input valid, input cmd, input index_lo, input index_hi,
                   input value, output ready);
endinterface

FILE: rtl/rmst_rsp_if.sv
// result channel: valid/ready plus the query minimum
// depends on rmst_pkg
interface rmst_rsp_if import rmst_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type minimum;

   modport source (output valid, output minimum, input ready);
   modport sink   (input valid, input minimum, output ready);
endinterface

FILE: rtl/range_min_segment_tree.sv
// Range minimum segment tree over LEAVES leaves, nodes kept in one ram of 2*LEAVES
// entries (node 1 is the root, leaf p is node LEAVES+p). A write updates the leaf in
// the cycle it is taken, then one ancestor per cycle, reading the sibling each
// cycle, up to the root. A query walks both bounds up one level over two phases,
// since each level may read two nodes through the single read port; an empty range
// goes straight to the finish state. A clear writes infinity through the write
// port one node per cycle after the transfer cycle, from node 0 to the last node;
// the same pass runs after reset, and req_ch.ready stays low while it runs. Unused
// commands are dropped and leave the block idle. A result sits in an output
// register, so the next command can be taken while it waits.
// depends on rmst_pkg, rmst_req_if, rmst_rsp_if, rmst_ram
module range_min_segment_tree import rmst_pkg::*; #(
   parameter int unsigned LEAVES = LEAVES_DEF
) (
   input logic         clock,
   input logic         reset,
   rmst_req_if.sink    req_ch,
   rmst_rsp_if.source  rsp_ch
);

   localparam int unsigned NODE_COUNT = 2 * LEAVES;
   localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
   localparam int unsigned CMP_W      = ((NODE_W > INDEX_W) ? NODE_W : INDEX_W) + 1;

   localparam logic [CMP_W-1:0]  LEAVES_C    = CMP_W'(LEAVES);
   localparam logic [CMP_W-1:0]  LAST_LEAF_C = CMP_W'(LEAVES - 1);
   localparam logic [NODE_W-1:0] LAST_NODE   = NODE_W'(NODE_COUNT - 1);
   localparam logic [NODE_W-1:0] ROOT_NODE   = NODE_W'(1);
   localparam logic [NODE_W-1:0] NODE_ONE    = NODE_W'(1);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_WRITE_UP = 3'd2;
   localparam logic [2:0] ST_QUERY    = 3'd3;
   localparam logic [2:0] ST_FINISH   = 3'd4;
   localparam logic [2:0] ST_RESULT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W-1:0] hi_ff, hi_in;
   value_type         best_ff, best_in;
   logic              pend_ff, pend_in;
   logic              phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_min_ff, rsp_min_in;

   logic              wr_en, rd_en;
   logic [NODE_W-1:0] wr_addr, rd_addr;
   value_type         wr_data, rd_data;

   logic              req_fire;
   logic [CMP_W-1:0]  lo_c, hi_c, hi_clamp;
   logic              lo_ok;
   logic [NODE_W-1:0] leaf_node, last_node_q;
   value_type         value_sat, merged, up_value;
   logic [NODE_W-1:0] parent, hi_dec;

   rmst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.minimum = rsp_min_ff;

   assign lo_c        = CMP_W'(req_ch.index_lo);
   assign hi_c        = CMP_W'(req_ch.index_hi);
   assign lo_ok       = (lo_c < LEAVES_C);
   assign hi_clamp    = (hi_c >= LEAVES_C) ? LAST_LEAF_C : hi_c;
   assign leaf_node   = NODE_W'(lo_c + LEAVES_C);
   assign last_node_q = NODE_W'(hi_clamp + LEAVES_C);
   assign value_sat   = (req_ch.value > INF_VALUE) ? INF_VALUE : req_ch.value;

   assign merged   = (pend_ff && (rd_data < best_ff)) ? rd_data : best_ff;
   assign up_value = (rd_data < best_ff) ? rd_data : best_ff;
   assign parent   = node_ff >> 1;
   assign hi_dec   = hi_ff[0] ? hi_ff : (hi_ff - NODE_ONE);

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      hi_in        = hi_ff;
      best_in      = best_ff;
      pend_in      = 1'b0;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_min_in   = rsp_min_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = INF_VALUE;
      rd_en        = 1'b0;
      rd_addr      = node_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            node_in = node_ff + NODE_ONE;
            if (node_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.cmd)
                  CMD_WRITE: begin
                     if (lo_ok) begin
                        wr_en    = 1'b1;
                        wr_addr  = leaf_node;
                        wr_data  = value_sat;
                        rd_en    = 1'b1;
                        rd_addr  = leaf_node ^ NODE_ONE;
                        node_in  = leaf_node;
                        best_in  = value_sat;
                        state_in = ST_WRITE_UP;
                     end
                  end
                  CMD_QUERY: begin
                     best_in  = INF_VALUE;
                     phase_in = 1'b0;
                     if (lo_ok && (lo_c <= hi_clamp)) begin
                        node_in  = leaf_node;
                        hi_in    = last_node_q;
                        state_in = ST_QUERY;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  CMD_CLEAR: begin
                     node_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE_UP: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = up_value;
            best_in = up_value;
            node_in = parent;
            if (parent == ROOT_NODE) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = parent ^ NODE_ONE;
            end
         end
         ST_QUERY: begin
            best_in = merged;
            if (!phase_ff) begin
               if (node_ff < hi_ff) begin
                  if (node_ff[0]) begin
                     rd_en   = 1'b1;
                     rd_addr = node_ff;
                     pend_in = 1'b1;
                     node_in = node_ff + NODE_ONE;
                  end
                  phase_in = 1'b1;
               end else begin
                  if (node_ff == hi_ff) begin
                     rd_en   = 1'b1;
                     rd_addr = hi_ff;
                     pend_in = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
            end else begin
               if (!hi_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = hi_ff;
                  pend_in = 1'b1;
               end
               hi_in    = hi_dec >> 1;
               node_in  = node_ff >> 1;
               phase_in = 1'b0;
            end
         end
         ST_FINISH: begin
            best_in  = merged;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = best_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         pend_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hi_ff      <= hi_in;
      best_ff    <= best_in;
      rsp_min_ff <= rsp_min_in;
   end

endmodule

FILE: rtl/rmst_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on rmst_pkg for default sizes
module rmst_ram import rmst_pkg::*; #(
   parameter int unsigned WIDTH = VALUE_W,
   parameter int unsigned DEPTH = 2 * LEAVES_DEF,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rmst_checker.sv
// port-level assertions for range_min_segment_tree, attached by bind
// depends on rmst_pkg and range_min_segment_tree_assert.svh
`include "range_min_segment_tree_assert.svh"

module rmst_checker import rmst_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input cmd_type   req_cmd,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type rsp_minimum
);

   // result transfer waits until taken
   `RMST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `RMST_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_minimum), "result changed while stalled")
   // a minimum never exceeds infinity
   `RMST_ASSERT(a_rsp_range, rsp_valid |-> rsp_minimum <= INF_VALUE, "minimum above infinity")
   // a query transfer keeps the block busy for at least the next cycle
   `RMST_ASSERT(a_query_busy, req_valid && req_ready && req_cmd == CMD_QUERY |=> !req_ready, "query finished in one cycle")
   // the clearing pass follows reset
   `RMST_ASSERT_ALWAYS(a_reset_clear, reset |=> !req_ready, "ready right after reset")

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_cmd     (req_ch.cmd),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_minimum (rsp_ch.minimum)
);

FILE: bench/tb_range_min_segment_tree.sv
`timescale 1ns / 1ps
// self-checking bench for range_min_segment_tree: writes, range queries and clears
// checked against a node-level mirror of the tree kept in the bench
// depends on rmst_pkg, rmst_req_if, rmst_rsp_if and the range_min_segment_tree rtl
module tb_range_min_segment_tree;
   import rmst_pkg::*;

   localparam int unsigned LEAVES       = LEAVES_DEF;
   localparam int unsigned NODES        = 2 * LEAVES;
   localparam int unsigned RANDOM_ITEMS = 1650;
   localparam int unsigned TAIL_CYCLES  = 64;
   localparam int unsigned LIMIT_CYCLES = 1000000;
   localparam cmd_type     CMD_UNUSED   = 2'd3;

   typedef struct packed {
      cmd_type   cmd;
      index_type index_lo;
      index_type index_hi;
      value_type value;
   } tree_cmd_type;

   logic clock;
   logic reset;

   rmst_req_if req_if ();
   rmst_rsp_if rsp_if ();

   range_min_segment_tree #(.LEAVES(LEAVES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   tree_cmd_type pending_cmds [$];
   value_type    expected_minima [$];
   value_type    tree_mirror [NODES];
   tree_cmd_type next_cmd;
   int unsigned  n_total;
   int unsigned  n_accepted;
   int unsigned  n_errors;
   int unsigned  cycle_count;
   int unsigned  send_gap;
   int unsigned  stall_left;
   bit           steady_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tree mirror
   function automatic value_type node_at(int unsigned k);
      if (k >= NODES) return INF_VALUE;
      return tree_mirror[k];
   endfunction

   function automatic void mirror_clear();
      for (int unsigned k = 0; k < NODES; k++) tree_mirror[k] = INF_VALUE;
   endfunction

   function automatic void mirror_write(index_type pos, value_type val);
      int unsigned k;
      value_type   left, right;
      if (pos >= LEAVES) return;
      k = pos + LEAVES;
      tree_mirror[k] = (val > INF_VALUE) ? INF_VALUE : val;
      k = k >> 1;
      while (k != 0) begin
         left  = node_at(2 * k);
         right = node_at(2 * k + 1);
         tree_mirror[k] = (left < right) ? left : right;
         k = k >> 1;
      end
   endfunction

   function automatic value_type mirror_query(index_type lo, index_type hi);
      int unsigned a, b, top;
      value_type   best;
      best = INF_VALUE;
      top  = (hi >= LEAVES) ? LEAVES - 1 : hi;
      if (lo >= LEAVES || lo > top) return INF_VALUE;
      a = lo + LEAVES;
      b = top + LEAVES;
      while (a < b) begin
         if (a % 2 == 1) begin
            if (node_at(a) < best) best = node_at(a);
            a++;
         end
         if (b % 2 == 0) begin
            if (node_at(b) < best) best = node_at(b);
            b--;
         end
         a = a >> 1;
         b = b >> 1;
      end
      if (a == b && node_at(b) < best) best = node_at(b);
      return best;
   endfunction

   // stimulus helpers
   function automatic void push_cmd(cmd_type cmd, int unsigned lo, int unsigned hi,
                                    int unsigned val);
      tree_cmd_type item;
      item.cmd      = cmd;
      item.index_lo = index_type'(lo);
      item.index_hi = index_type'(hi);
      item.value    = value_type'(val);
      pending_cmds.push_back(item);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2: return $urandom_range(0, 15);
         3, 4:    return $urandom_range(0, 1000);
         5, 6:    return $urandom_range(0, INF_VALUE);
         7:       return INF_VALUE;
         8:       return $urandom & 32'hFF_FFFF;
         default: return $urandom_range(INF_VALUE - 1, INF_VALUE + 1);
      endcase
   endfunction

   function automatic int unsigned near_index(int unsigned base, int unsigned span);
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, LEAVES - 1);
      return (base + $urandom_range(0, span)) % LEAVES;
   endfunction

   task automatic note_mismatch(string msg);
      if (n_errors < 10) $display("%s", msg);
      n_errors++;
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0 || pending_cmds.size() == 0) begin
            req_if.valid <= 1'b0;
            if (send_gap != 0) send_gap <= send_gap - 1;
         end else begin
            next_cmd = pending_cmds.pop_front();
            req_if.valid    <= 1'b1;
            req_if.cmd      <= next_cmd.cmd;
            req_if.index_lo <= next_cmd.index_lo;
            req_if.index_hi <= next_cmd.index_hi;
            req_if.value    <= next_cmd.value;
            send_gap        <= pick_gap();
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left   <= pick_gap();
      end
   end

   // command monitor feeding the mirror
   always @(posedge clock) begin
      if (reset) begin
         mirror_clear();
      end else if (req_if.valid && req_if.ready) begin
         n_accepted++;
         case (req_if.cmd)
            CMD_WRITE: mirror_write(req_if.index_lo, req_if.value);
            CMD_QUERY: expected_minima.push_back(mirror_query(req_if.index_lo,
                                                             req_if.index_hi));
            CMD_CLEAR: mirror_clear();
            default: ;
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_minima.size() == 0) begin
            note_mismatch($sformatf("unexpected result transfer: minimum %0d",
                                    rsp_if.minimum));
         end else if (rsp_if.minimum !== expected_minima[0]) begin
            note_mismatch($sformatf("minimum mismatch: expected %0d, got %0d",
                                    expected_minima[0], rsp_if.minimum));
            void'(expected_minima.pop_front());
         end else begin
            void'(expected_minima.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if ($urandom_range(0, 299) == 0) steady_phase <= !steady_phase;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_range_min_segment_tree: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned counted, pick, base, span, lo, hi, tmp;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.cmd      = CMD_WRITE;
      req_if.index_lo = '0;
      req_if.index_hi = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      n_accepted      = 0;
      n_errors        = 0;
      cycle_count     = 0;
      steady_phase    = 1'b0;

      // directed part
      push_cmd(CMD_QUERY, 0, LEAVES - 1, 0);
      push_cmd(CMD_WRITE, 0, LEAVES - 1, 0);
      push_cmd(CMD_WRITE, LEAVES - 1, 0, 24'hFF_FFFF);
      push_cmd(CMD_QUERY, LEAVES - 1, LEAVES - 1, 24'hFF_FFFF);
      push_cmd(CMD_WRITE, 512, 0, 5);
      push_cmd(CMD_QUERY, 0, LEAVES - 1, 0);
      push_cmd(CMD_QUERY, 1, LEAVES - 1, 0);
      push_cmd(CMD_QUERY, 513, LEAVES - 1, 0);
      push_cmd(CMD_QUERY, 600, 100, 0);
      push_cmd(CMD_WRITE, LEAVES - 1, 0, INF_VALUE - 1);
      push_cmd(CMD_QUERY, 1000, LEAVES - 1, 0);
      push_cmd(CMD_UNUSED, 0, 0, 0);
      push_cmd(CMD_QUERY, 0, 0, 0);
      push_cmd(CMD_WRITE, 0, 0, INF_VALUE);
      push_cmd(CMD_QUERY, 0, LEAVES - 1, 0);
      push_cmd(CMD_WRITE, 341, 10'h2AA, 24'h55_5555);
      push_cmd(CMD_WRITE, 682, 10'h155, 24'hAA_AAAA);
      push_cmd(CMD_QUERY, 341, 682, 24'hFF_FFFF);
      push_cmd(CMD_CLEAR, 10'h3FF, 10'h3FF, 24'hFF_FFFF);
      push_cmd(CMD_QUERY, 0, LEAVES - 1, 0);
      push_cmd(CMD_WRITE, LEAVES - 1, 0, 0);
      push_cmd(CMD_QUERY, LEAVES - 2, LEAVES - 1, 0);
      push_cmd(CMD_QUERY, 0, LEAVES - 2, 0);

      // random part, clustered around a moving window so queries see written leaves
      counted = 0;
      base    = $urandom_range(0, LEAVES - 1);
      span    = 32;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 49) == 0) begin
            base = $urandom_range(0, LEAVES - 1);
            span = ($urandom_range(0, 4) == 0) ? LEAVES - 1 : $urandom_range(1, 64);
         end
         lo   = near_index(base, span);
         hi   = near_index(base, span);
         pick = $urandom_range(0, 999);
         if (pick < 6) begin
            push_cmd(CMD_CLEAR, lo, hi, $urandom);
            counted++;
         end else if (pick < 25) begin
            push_cmd(CMD_UNUSED, lo, hi, $urandom);
         end else if (pick < 525) begin
            push_cmd(CMD_WRITE, lo, hi, pick_value());
            counted++;
         end else begin
            case ($urandom_range(0, 9))
               0: if (lo < hi) begin
                     tmp = lo;
                     lo  = hi;
                     hi  = tmp;
                  end
               1: hi = lo;
               2: begin
                     lo = ($urandom_range(0, 1) == 0) ? 0 : lo;
                     hi = LEAVES - 1;
                  end
               default: if (lo > hi) begin
                     tmp = lo;
                     lo  = hi;
                     hi  = tmp;
                  end
            endcase
            push_cmd(CMD_QUERY, lo, hi, $urandom);
            counted++;
         end
      end
      n_total = pending_cmds.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (n_accepted < n_total || expected_minima.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_minima.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_minima.size()));
      if (n_errors == 0) begin
         $display("tb_range_min_segment_tree: PASS");
      end else begin
         $display("tb_range_min_segment_tree: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rmst_pkg.sv
rtl/rmst_req_if.sv
rtl/rmst_rsp_if.sv
rtl/rmst_ram.sv
rtl/range_min_segment_tree.sv
rtl/rmst_checker.sv
bench/tb_range_min_segment_tree.sv
